// ===== hdl/mexp_pkg.sv =====
// shared constants and controller/datapath interface types for modular exponentiation
package mexp_pkg;

    localparam int OPERAND_WIDTH = 32;
    localparam int EXP_W         = 63;
    localparam int BASE_W        = 32;
    localparam int MOD_W         = 32;
    localparam int OUT_W         = 32;
    localparam int CNT_W         = $clog2(OPERAND_WIDTH);

    typedef struct packed {
        logic load;       // capture a new operand beat
        logic red_start;  // begin reducing the base by the modulus
        logic step;       // advance both multiplier lanes by one bit
        logic reduce;     // lanes run the base reduction pass
        logic finish;     // latch the final result
    } t_mexp_cmd;

    typedef struct packed {
        logic exp_zero;       // captured exponent was zero
        logic mod_zero;       // captured modulus was zero
        logic cnt_last;       // lane bit counter on its last step
        logic exp_rest_zero;  // no set exponent bit above the current one
    } t_mexp_sts;

endpackage

// ===== hdl/modular_exponentiation.sv =====
// top level of the modular exponentiation block
// Computes base ** exponent mod modulus by right-to-left square-and-multiply. One result
// beat follows each input beat. The base is first reduced by the modulus in one pass;
// then one pass runs for each exponent bit up to the highest set one, in which the square
// and the conditional multiply run side by side on two bit-serial interleaved modular
// multiplier lanes, one multiplier bit per cycle. A zero exponent returns 1, and a zero
// modulus with nonzero exponent returns 0. A new beat is taken once the previous item has
// left the loop, even while its result still waits downstream.
module modular_exponentiation
    import mexp_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [127:0] s_axis_tdata,   // base[31:0], exponent[94:32], modulus[126:95], pad
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [31:0]  m_axis_tdata    // power_mod[31:0]
);

    t_mexp_cmd cmd;
    t_mexp_sts sts;

    mexp_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (s_axis_tvalid),
        .o_s_ready (s_axis_tready),
        .o_m_valid (m_axis_tvalid),
        .i_m_ready (m_axis_tready),
        .o_cmd     (cmd),
        .i_sts     (sts)
    );

    mexp_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_base      (s_axis_tdata[31:0]),
        .i_exponent  (s_axis_tdata[94:32]),
        .i_modulus   (s_axis_tdata[126:95]),
        .o_sts       (sts),
        .o_power_mod (m_axis_tdata)
    );

endmodule

// ===== hdl/mexp_ctrl.sv =====
// sequencer for square-and-multiply: stream handshakes and datapath commands
module mexp_ctrl
    import mexp_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_s_valid,
    output logic      o_s_ready,
    output logic      o_m_valid,
    input  logic      i_m_ready,
    output t_mexp_cmd o_cmd,
    input  t_mexp_sts i_sts
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_CHK  = 3'd1;
    localparam logic [2:0] ST_RED  = 3'd2;
    localparam logic [2:0] ST_BIT  = 3'd3;
    localparam logic [2:0] ST_DONE = 3'd4;

    logic [2:0] r_state, n_state;
    logic       r_mvalid, n_mvalid;
    logic       out_free;

    assign out_free  = !r_mvalid || i_m_ready;
    assign o_s_ready = (r_state == ST_IDLE);
    assign o_m_valid = r_mvalid;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_s_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_CHK;
                end
            end
            ST_CHK: begin
                if (i_sts.exp_zero || i_sts.mod_zero) begin
                    n_state = ST_DONE;
                end else begin
                    o_cmd.red_start = 1'b1;
                    n_state         = ST_RED;
                end
            end
            ST_RED: begin
                o_cmd.step   = 1'b1;
                o_cmd.reduce = 1'b1;
                if (i_sts.cnt_last) begin
                    n_state = ST_BIT;
                end
            end
            ST_BIT: begin
                o_cmd.step = 1'b1;
                if (i_sts.cnt_last && i_sts.exp_rest_zero) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        if (o_cmd.finish) begin
            n_mvalid = 1'b1;
        end else if (i_m_ready) begin
            n_mvalid = 1'b0;
        end else begin
            n_mvalid = r_mvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_mvalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_mvalid <= n_mvalid;
        end
    end

    // the main loop only runs for a nonzero exponent and modulus
    a_loop_operands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RED || r_state == ST_BIT) |-> (!i_sts.exp_zero && !i_sts.mod_zero))
        else $error("loop entered with trivial operands");

    a_finish_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.finish |=> (r_mvalid && r_state == ST_IDLE))
        else $error("finished result not presented");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mvalid && !i_m_ready) |-> !o_cmd.finish)
        else $error("pending result overwritten");

endmodule

// ===== hdl/mexp_dp.sv =====
// operand registers and two bit-serial modular multiplier lanes sharing one multiplicand
module mexp_dp
    import mexp_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_mexp_cmd                i_cmd,
    input  logic [BASE_W-1:0]        i_base,
    input  logic [EXP_W-1:0]         i_exponent,
    input  logic [MOD_W-1:0]         i_modulus,
    output t_mexp_sts                o_sts,
    output logic [OUT_W-1:0]         o_power_mod
);

    localparam int OPW = OPERAND_WIDTH;

    logic [OPW-1:0]   r_mod;
    logic [EXP_W-1:0] r_exp;
    logic             r_exp_zero;
    logic             r_mod_zero;
    logic [OPW-1:0]   r_base;
    logic [OPW-1:0]   r_sq;
    logic [OPW-1:0]   r_acc;
    logic [OPW-1:0]   r_ps;   // square lane partial result
    logic [OPW-1:0]   r_pm;   // multiply lane partial result
    logic [OPW-1:0]   r_bs;   // square lane multiplier bits, msb first
    logic [OPW-1:0]   r_bm;   // multiply lane multiplier bits, msb first
    logic [CNT_W-1:0] r_cnt;
    logic [OPW-1:0]   r_res;

    logic [OPW-1:0]   mcand;
    logic [OPW-1:0]   ps_n;
    logic [OPW-1:0]   pm_n;
    logic [OPW-1:0]   acc_n;

    // one step of interleaved multiply: r = (2r + bit*a) mod m, with r < m and a <= m
    function automatic logic [OPW-1:0] lane_step(
        input logic [OPW-1:0] r,
        input logic [OPW-1:0] a,
        input logic [OPW-1:0] m,
        input logic           b
    );
        logic [OPW:0] t;
        logic [OPW:0] u;
        t = {r, 1'b0};
        if (t >= {1'b0, m}) begin
            t = t - {1'b0, m};
        end
        u = t + (b ? {1'b0, a} : '0);
        if (u >= {1'b0, m}) begin
            u = u - {1'b0, m};
        end
        return u[OPW-1:0];
    endfunction

    // the reduction pass multiplies the base by one
    assign mcand = i_cmd.reduce ? OPW'(1) : r_sq;
    assign ps_n  = lane_step(r_ps, mcand, r_mod, r_bs[OPW-1]);
    assign pm_n  = lane_step(r_pm, mcand, r_mod, r_bm[OPW-1]);
    assign acc_n = (!i_cmd.reduce && r_exp[0]) ? pm_n : r_acc;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_base     <= i_base[OPW-1:0];
            r_mod      <= i_modulus[OPW-1:0];
            r_exp      <= i_exponent;
            r_exp_zero <= (i_exponent == '0);
            r_mod_zero <= (i_modulus[OPW-1:0] == '0);
            r_acc      <= OPW'(1);
        end else if (i_cmd.red_start) begin
            r_bs  <= r_base;
            r_ps  <= '0;
            r_pm  <= '0;
            r_cnt <= CNT_W'(OPW - 1);
        end else if (i_cmd.step) begin
            if (r_cnt == '0) begin
                // end of a pass: commit and reload both lanes for the next exponent bit
                r_sq  <= ps_n;
                r_acc <= acc_n;
                r_bs  <= ps_n;
                r_bm  <= acc_n;
                r_ps  <= '0;
                r_pm  <= '0;
                r_cnt <= CNT_W'(OPW - 1);
                if (!i_cmd.reduce) begin
                    r_exp <= r_exp >> 1;
                end
            end else begin
                r_ps  <= ps_n;
                r_pm  <= pm_n;
                r_bs  <= r_bs << 1;
                r_bm  <= r_bm << 1;
                r_cnt <= r_cnt - CNT_W'(1);
            end
        end

        if (i_cmd.finish) begin
            if (r_exp_zero) begin
                r_res <= OPW'(1);
            end else if (r_mod_zero) begin
                r_res <= '0;
            end else begin
                r_res <= r_acc;
            end
        end
    end

    assign o_sts.exp_zero      = r_exp_zero;
    assign o_sts.mod_zero      = r_mod_zero;
    assign o_sts.cnt_last      = (r_cnt == '0);
    assign o_sts.exp_rest_zero = (r_exp[EXP_W-1:1] == '0);
    assign o_power_mod         = OUT_W'(r_res);

    a_sq_lane_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.step && !r_mod_zero) |-> (r_ps < r_mod))
        else $error("square lane partial not reduced");

    a_main_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.step && !i_cmd.reduce && !r_mod_zero) |->
            (r_sq < r_mod && r_pm < r_mod))
        else $error("running square or product not reduced");

endmodule
